### rtl/tversky_similarity_assert.svh
// Assertion macros shared by the checker files of the similarity block.
// No dependencies; take in by `include before the module that asserts.
`ifndef TVERSKY_SIMILARITY_ASSERT_SVH
`define TVERSKY_SIMILARITY_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TVS_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tvs: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define TVS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tvs: next-cycle check failed");

`endif

### rtl/tvs_pkg.sv
// Types and constants of the Tversky similarity pipeline.
// No dependencies; other modules use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tvs_pkg;

  localparam int unsigned CntW         = 12;
  localparam int unsigned WgtW         = 16;
  localparam int unsigned SimW         = 16;
  localparam int unsigned ProdW        = CntW + WgtW;
  localparam int unsigned DenW         = ProdW + 2;
  localparam int unsigned NumShift     = 29;
  localparam int unsigned NumW         = CntW + NumShift;
  localparam int unsigned QuoW         = 16;
  localparam int unsigned DsW          = DenW + QuoW - 1;
  localparam int unsigned CmpW         = DsW + 1;
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned DivStages    = QuoW / BitsPerStage;
  localparam int unsigned OneShiftQ14  = 14;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [SimW-1:0] OneQ15 = 16'h8000;
  localparam logic [WgtW-1:0] OneQ14 = 16'h4000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWeightA  = 2'd0,
    CfgWeightB  = 2'd1,
    CfgZeroMode = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CntW-1:0] count_first;
    logic [CntW-1:0] count_second;
    logic [CntW-1:0] common_count;
  } in_item_t;

  typedef struct packed {
    logic [SimW-1:0] similarity;
    logic            bad_input;
  } out_item_t;

  typedef struct packed {
    logic [WgtW-1:0] weight_a;
    logic [WgtW-1:0] weight_b;
    logic            zero_count_mode;
  } cfg_t;

  typedef struct packed {
    logic [ProdW-1:0] p_first;
    logic [ProdW-1:0] p_second;
    logic [CntW-1:0]  common;
    logic [CntW:0]    other_inc;
    logic             bad_common;
    logic             both_zero;
    logic             one_zero;
    logic             zero_mode;
  } mul_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [DsW-1:0]  ds;
    logic [QuoW-1:0] quo;
    logic            force_en;
    logic [SimW-1:0] force_sim;
    logic            bad;
  } div_t;

endpackage

`default_nettype wire

### rtl/tvs_front.sv
// Front of the pipeline: weight products, then denominator and case selection.
// Depends on tvs_pkg; feeds tvs_div.
`timescale 1ns / 1ps
`default_nettype none

module tvs_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tvs_pkg::cfg_t    cfg_i,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire tvs_pkg::in_item_t data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output tvs_pkg::div_t         data_o
);

  logic                       mul_valid_q;
  logic                       mul_ready;
  tvs_pkg::mul_t              mul_d, mul_q;
  logic                       div_valid_q;
  tvs_pkg::div_t              div_d, div_q;
  logic [tvs_pkg::CntW-1:0]   diff_first, diff_second;
  logic [tvs_pkg::DenW-1:0]   den_sum;
  logic [tvs_pkg::DenW-1:0]   den_sel;

  assign mul_ready = !div_valid_q || ready_i;
  assign ready_o   = !mul_valid_q || mul_ready;

  // product stage
  always_comb begin
    diff_first  = data_i.count_first - data_i.common_count;
    diff_second = data_i.count_second - data_i.common_count;
    mul_d = '0;
    mul_d.p_first    = tvs_pkg::ProdW'(cfg_i.weight_a) * tvs_pkg::ProdW'(diff_first);
    mul_d.p_second   = tvs_pkg::ProdW'(cfg_i.weight_b) * tvs_pkg::ProdW'(diff_second);
    mul_d.common     = data_i.common_count;
    mul_d.bad_common = (data_i.common_count > data_i.count_first) ||
                       (data_i.common_count > data_i.count_second);
    mul_d.both_zero  = (data_i.count_first == '0) && (data_i.count_second == '0);
    mul_d.one_zero   = (data_i.count_first == '0) || (data_i.count_second == '0);
    mul_d.zero_mode  = cfg_i.zero_count_mode;
    mul_d.other_inc  = ((data_i.count_first == '0) ? {1'b0, data_i.count_second}
                                                   : {1'b0, data_i.count_first}) +
                       (tvs_pkg::CntW + 1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (ready_o) begin
      mul_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mul_q <= mul_d;
    end
  end

  // denominator and special-case stage
  always_comb begin
    den_sum = tvs_pkg::DenW'(mul_q.p_first) + tvs_pkg::DenW'(mul_q.p_second) +
              (tvs_pkg::DenW'(mul_q.common) << tvs_pkg::OneShiftQ14);
    den_sel = '0;
    div_d   = '0;
    priority if (mul_q.bad_common) begin
      div_d.force_en = 1'b1;
      div_d.bad      = 1'b1;
    end else if (mul_q.both_zero) begin
      div_d.force_en  = 1'b1;
      div_d.force_sim = tvs_pkg::OneQ15;
    end else if (mul_q.one_zero) begin
      if (mul_q.zero_mode) begin
        div_d.rem = tvs_pkg::NumW'(tvs_pkg::OneQ15);
        den_sel   = tvs_pkg::DenW'(mul_q.other_inc);
      end else begin
        div_d.force_en = 1'b1;
      end
    end else if (den_sum == '0) begin
      div_d.force_en = 1'b1;
      div_d.bad      = 1'b1;
    end else begin
      div_d.rem = tvs_pkg::NumW'(mul_q.common) << tvs_pkg::NumShift;
      den_sel   = den_sum;
    end
    div_d.ds = tvs_pkg::DsW'(den_sel) << (tvs_pkg::QuoW - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_valid_q <= 1'b0;
    end else if (mul_ready) begin
      div_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_valid_q && mul_ready) begin
      div_q <= div_d;
    end
  end

  assign valid_o = div_valid_q;
  assign data_o  = div_q;

endmodule

`default_nettype wire

### rtl/tvs_div_stage.sv
// One divider stage: two restoring quotient steps, then a register.
// Depends on tvs_pkg; chained by tvs_div.
`timescale 1ns / 1ps
`default_nettype none

module tvs_div_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire tvs_pkg::div_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output tvs_pkg::div_t      data_o
);

  logic          valid_q;
  tvs_pkg::div_t data_q;
  tvs_pkg::div_t walk [tvs_pkg::BitsPerStage+1];
  logic          fits [tvs_pkg::BitsPerStage];

  assign ready_o = !valid_q || ready_i;

  // compare, subtract, shift in the quotient bit, halve the divisor
  always_comb begin
    walk[0] = data_i;
    for (int unsigned s = 0; s < tvs_pkg::BitsPerStage; s++) begin
      walk[s+1] = walk[s];
      fits[s]   = tvs_pkg::CmpW'(walk[s].rem) >= tvs_pkg::CmpW'(walk[s].ds);
      if (fits[s]) begin
        walk[s+1].rem = walk[s].rem - tvs_pkg::NumW'(walk[s].ds);
      end
      walk[s+1].quo = {walk[s].quo[tvs_pkg::QuoW-2:0], fits[s]};
      walk[s+1].ds  = walk[s].ds >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= walk[tvs_pkg::BitsPerStage];
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### rtl/tvs_div.sv
// Pipelined restoring divider: a chain of tvs_div_stage, two quotient bits each.
// Depends on tvs_pkg and tvs_div_stage.
`timescale 1ns / 1ps
`default_nettype none

module tvs_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire tvs_pkg::div_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output tvs_pkg::div_t      data_o
);

  logic [tvs_pkg::DivStages:0] chain_valid;
  logic [tvs_pkg::DivStages:0] chain_ready;
  tvs_pkg::div_t               chain_data [tvs_pkg::DivStages+1];

  assign chain_valid[0]                  = valid_i;
  assign chain_data[0]                   = data_i;
  assign ready_o                         = chain_ready[0];
  assign chain_ready[tvs_pkg::DivStages] = ready_i;
  assign valid_o                         = chain_valid[tvs_pkg::DivStages];
  assign data_o                          = chain_data[tvs_pkg::DivStages];

  for (genvar g = 0; g < tvs_pkg::DivStages; g++) begin : g_stage
    tvs_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

endmodule

`default_nettype wire

### rtl/tversky_similarity.sv
// Top level of the Tversky similarity block: configuration registers,
// front stages, pipelined divider and output register. Depends on tvs_pkg.
//
//   Channel  Direction  Handshake                Payload
//   in       sink       in_valid_i / in_ready_o   tvs_pkg::in_item_t
//   out      source     out_valid_o / out_ready_i tvs_pkg::out_item_t
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction enters per cycle unless back-pressure stalls the input;
// each passes from input to output through the product stage, denominator
// stage, eight divider stages of two quotient bits each and output register.
// Reset clears every valid bit and loads the weights with 1.0 and mode 0.
// A stage holds only while the stage after it is full and stalled, so bubbles
// close up and input is taken while a result waits at the output.
`timescale 1ns / 1ps
`default_nettype none

module tversky_similarity (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire tvs_pkg::in_item_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output tvs_pkg::out_item_t                   out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tvs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [tvs_pkg::WgtW-1:0]        cfg_data_i
);

  tvs_pkg::cfg_t      cfg_q;
  logic               front_valid, front_ready;
  tvs_pkg::div_t      front_data;
  logic               div_valid, div_ready;
  tvs_pkg::div_t      div_data;
  logic               out_valid_q;
  tvs_pkg::out_item_t out_d, out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight_a        <= tvs_pkg::OneQ14;
      cfg_q.weight_b        <= tvs_pkg::OneQ14;
      cfg_q.zero_count_mode <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tvs_pkg::CfgWeightA:  cfg_q.weight_a        <= cfg_data_i;
        tvs_pkg::CfgWeightB:  cfg_q.weight_b        <= cfg_data_i;
        tvs_pkg::CfgZeroMode: cfg_q.zero_count_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tvs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (front_valid),
    .ready_i (front_ready),
    .data_o  (front_data)
  );

  tvs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .data_i  (front_data),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .data_o  (div_data)
  );

  assign div_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_d.similarity = div_data.force_en ? div_data.force_sim : div_data.quo;
    out_d.bad_input  = div_data.bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_valid && div_ready) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/tvs_chk.sv
// Port checker of the similarity block, bound to the top level.
// Depends on tvs_pkg and tversky_similarity_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "tversky_similarity_assert.svh"

module tvs_chk (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire tvs_pkg::out_item_t out_data_i
);

  `TVS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `TVS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))
  `TVS_ASSERT_NOW(a_sim_range, clk_i, rst_ni, out_valid_i, out_data_i.similarity <= tvs_pkg::OneQ15)
  `TVS_ASSERT_NOW(a_bad_zero, clk_i, rst_ni, out_valid_i && out_data_i.bad_input, out_data_i.similarity == '0)

endmodule

bind tversky_similarity tvs_chk u_tvs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the Tversky similarity block: directed and random
// transactions are scored by a local predictor and compared at the output.
// Depends on tvs_pkg and tversky_similarity.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PipeLatency = 11;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 250;
  localparam int unsigned MaxReports  = 10;

  logic                       clk       = 1'b0;
  logic                       rst_ni    = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  tvs_pkg::in_item_t          in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  tvs_pkg::out_item_t         out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  tvs_pkg::cfg_idx_e          cfg_index = tvs_pkg::CfgWeightA;
  logic [tvs_pkg::WgtW-1:0]   cfg_data  = '0;

  tvs_pkg::cfg_t      settings;
  tvs_pkg::out_item_t pending_scores[$];
  tvs_pkg::out_item_t want;
  int unsigned failures      = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_cnt      = 0;
  int unsigned stall_cnt     = 0;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;

  tversky_similarity dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic tvs_pkg::out_item_t tversky_score(input tvs_pkg::in_item_t pair);
    logic [63:0] n1;
    logic [63:0] n2;
    logic [63:0] c;
    logic [63:0] other;
    logic [63:0] den;
    logic [63:0] quo;
    tvs_pkg::out_item_t res;
    n1 = 64'(pair.count_first);
    n2 = 64'(pair.count_second);
    c  = 64'(pair.common_count);
    res.similarity = '0;
    res.bad_input  = 1'b0;
    if (c > n1 || c > n2) begin
      res.bad_input = 1'b1;
    end else if (n1 == 0 || n2 == 0) begin
      other = (n1 != 0) ? n1 : n2;
      if (n1 == 0 && n2 == 0) begin
        res.similarity = tvs_pkg::OneQ15;
      end else if (settings.zero_count_mode) begin
        quo = 64'(tvs_pkg::OneQ15) / (other + 1);
        res.similarity = quo[tvs_pkg::SimW-1:0];
      end
    end else begin
      den = 64'(settings.weight_a) * (n1 - c) + 64'(settings.weight_b) * (n2 - c)
            + (c << tvs_pkg::OneShiftQ14);
      if (den == 0) begin
        res.bad_input = 1'b1;
      end else begin
        quo = (c << tvs_pkg::NumShift) / den;
        if (quo > 64'(tvs_pkg::OneQ15)) quo = 64'(tvs_pkg::OneQ15);
        res.similarity = quo[tvs_pkg::SimW-1:0];
      end
    end
    return res;
  endfunction

  function automatic int unsigned burst_len(input bit enable);
    if (enable && $urandom_range(0, 3) == 0) return $urandom_range(1, 18);
    return 0;
  endfunction

  function automatic tvs_pkg::in_item_t make_pair(input int unsigned n1,
                                                  input int unsigned n2,
                                                  input int unsigned c);
    tvs_pkg::in_item_t p;
    p.count_first  = n1[tvs_pkg::CntW-1:0];
    p.count_second = n2[tvs_pkg::CntW-1:0];
    p.common_count = c[tvs_pkg::CntW-1:0];
    return p;
  endfunction

  function automatic tvs_pkg::in_item_t random_pair();
    int unsigned n1;
    int unsigned n2;
    int unsigned lim;
    n1 = $urandom_range(1, 2048);
    n2 = $urandom_range(1, 2048);
    case ($urandom_range(0, 9))
      0: return make_pair($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095));
      1: begin
        if ($urandom_range(0, 1)) n1 = 0;
        else n2 = 0;
        if ($urandom_range(0, 7) == 0) n1 = 0;
        return make_pair(n1, n2, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 0);
      end
      2: begin
        n1 = $urandom_range(2048, 4095);
        n2 = $urandom_range(1, 4095);
      end
      3: begin
        lim = (n1 < n2) ? n1 : n2;
        return make_pair(n1, n2, lim + $urandom_range(1, 8));
      end
      default: ;
    endcase
    lim = (n1 < n2) ? n1 : n2;
    if ($urandom_range(0, 5) == 0) return make_pair(n1, n2, lim);
    return make_pair(n1, n2, $urandom_range(0, lim));
  endfunction

  function automatic logic [tvs_pkg::WgtW-1:0] random_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'd32768;
      2: return tvs_pkg::OneQ14;
      default: return tvs_pkg::WgtW'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic send_pair(input tvs_pkg::in_item_t pair);
    int unsigned gap;
    gap = burst_len(tx_idle_en);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    do @(posedge clk); while (!in_ready);
    pending_scores.push_back(tversky_score(pair));
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pair(random_pair());
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (PipeLatency + 2) @(posedge clk);
  endtask

  task automatic set_config(input logic [tvs_pkg::WgtW-1:0] wa,
                            input logic [tvs_pkg::WgtW-1:0] wb,
                            input logic mode);
    quiesce();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      case (i)
        0: begin cfg_index <= tvs_pkg::CfgWeightA;  cfg_data <= wa; end
        1: begin cfg_index <= tvs_pkg::CfgWeightB;  cfg_data <= wb; end
        default: begin
          cfg_index <= tvs_pkg::CfgZeroMode;
          cfg_data  <= tvs_pkg::WgtW'(mode);
        end
      endcase
      do @(posedge clk); while (!cfg_ready);
      case (i)
        0: settings.weight_a = wa;
        1: settings.weight_b = wb;
        default: settings.zero_count_mode = mode;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_pair(make_pair(0, 0, 0));
    send_pair(make_pair(0, 5, 0));
    send_pair(make_pair(7, 0, 0));
    send_pair(make_pair(0, 0, 1));
    send_pair(make_pair(3, 5, 4));
    send_pair(make_pair(4095, 4095, 4095));
    send_pair(make_pair(2048, 2048, 0));
    send_pair(make_pair(4095, 1, 1));
    send_pair(make_pair(1, 4095, 0));
    send_pair(make_pair(2048, 1024, 512));
  endtask

  task automatic test_zero_count_mode();
    set_config(tvs_pkg::OneQ14, tvs_pkg::OneQ14, 1'b1);
    send_pair(make_pair(0, 1, 0));
    send_pair(make_pair(0, 4095, 0));
    send_pair(make_pair(2048, 0, 0));
    send_pair(make_pair(0, 0, 0));
    send_pair(make_pair(0, 3, 1));
  endtask

  task automatic test_zero_denominator();
    set_config('0, '0, 1'b0);
    send_pair(make_pair(5, 7, 0));
    send_pair(make_pair(5, 7, 3));
    send_pair(make_pair(4095, 4095, 0));
  endtask

  task automatic test_weight_extremes();
    set_config(16'd32768, 16'd32768, 1'b1);
    send_pair(make_pair(100, 200, 50));
    send_pair(make_pair(4095, 4095, 1));
    send_pair(make_pair(0, 2048, 0));
    set_config(16'hFFFF, '0, 1'b0);
    send_pair(make_pair(4095, 9, 1));
    send_pair(make_pair(9, 4095, 0));
    send_pair(make_pair(2048, 2048, 2047));
  endtask

  task automatic test_random_config();
    repeat (6) begin
      set_config(random_weight(), random_weight(), 1'($urandom_range(0, 1)));
      send_random(55);
    end
  endtask

  task automatic test_backpressure();
    set_config(random_weight(), random_weight(), 1'b1);
    tx_idle_en   = 1'b0;
    hold_request = HoldCycles;
    send_random(40);
    tx_idle_en   = 1'b1;
  endtask

  task automatic test_streaming();
    set_config(tvs_pkg::OneQ14, 16'd8192, 1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(60);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_cnt     = hold_request;
        hold_request = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else begin
        stall_cnt = burst_len(rx_idle_en);
        if (stall_cnt > 0) begin
          stall_cnt--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("unexpected result: similarity %0d bad_input %0d",
                   out_data.similarity, out_data.bad_input);
      end else begin
        want = pending_scores.pop_front();
        if (out_data.similarity !== want.similarity || out_data.bad_input !== want.bad_input)
        begin
          failures++;
          if (failures <= MaxReports)
            $display("mismatch: expected similarity %0d bad_input %0d, got %0d %0d",
                     want.similarity, want.bad_input, out_data.similarity,
                     out_data.bad_input);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    settings.weight_a        = tvs_pkg::OneQ14;
    settings.weight_b        = tvs_pkg::OneQ14;
    settings.zero_count_mode = 1'b0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_count_mode();
    test_zero_denominator();
    test_weight_extremes();
    test_random_config();
    test_backpressure();
    test_streaming();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (PipeLatency + 5) @(posedge clk);
    if (failures == 0 && pending_scores.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
